/* sv/map_region_through_alignment_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the alignment liftover block
// Clocked concurrent checks; define ASSERT_OFF to drop them all.
// ----------------------------------------------------------------------------
`ifndef MAP_REGION_THROUGH_ALIGNMENT_MACROS_SVH
`define MAP_REGION_THROUGH_ALIGNMENT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every edge out of reset.
`define MRTA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define MRTA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define MRTA_ASSERT(lbl, prop, msg)
`define MRTA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* sv/mrta_pkg.sv */
// ----------------------------------------------------------------------------
// mrta_pkg
// Shared types and constants of the alignment liftover block.
// ----------------------------------------------------------------------------
package mrta_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 1024;

  localparam int unsigned POS_W = 32;   // coordinates
  localparam int unsigned IDX_W = 10;   // entry_index field
  localparam int unsigned CNT_W = 11;   // block_count register

  localparam int unsigned S_TDATA_W = 176;
  localparam int unsigned M_TDATA_W = 64;

  // APB register select, decoded from paddr[2]
  localparam logic REG_MINUS_STRAND = 1'b0;
  localparam logic REG_BLOCK_COUNT  = 1'b1;

  // input word kind (tuser)
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_MAP  = 1'b1;

  // one table entry, stored as a single RAM word
  typedef struct packed {
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] qs;
    logic [POS_W-1:0] ts;
  } blk_entry_t;

  localparam int unsigned ENTRY_W = $bits(blk_entry_t);

  // controller -> datapath
  typedef struct packed {
    logic load_wr;    // write accepted load word into the table
    logic start_map;  // latch region, start scan for first end
    logic scan;       // scan in progress
    logic clamp;      // clamp offset and form mapped position
    logic next_end;   // restart scan for the last end
    logic load_out;   // move result into output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic hit;
    logic end_last;
    logic out_free;
  } dp_status_t;

endpackage

/* sv/mrta_ram.sv */
// ----------------------------------------------------------------------------
// mrta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrta_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/mrta_ctrl.sv */
// ----------------------------------------------------------------------------
// mrta_ctrl
// Sequencer: accept, scan per end, clamp, hand result to output register.
// ----------------------------------------------------------------------------
module mrta_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_kind_i,
  output logic                   in_ready_o,
  input  mrta_pkg::dp_status_t   status_i,
  output mrta_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_CLAMP = 4'b0100,
    ST_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == mrta_pkg::KIND_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            cmd_o.start_map = 1'b1;
            state_d = status_i.count_zero ? ST_OUT : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.hit) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
        if (status_i.end_last) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.next_end = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/mrta_dp.sv */
// ----------------------------------------------------------------------------
// mrta_dp
// Block table, downward scan, clamp/offset arithmetic and output register.
// ----------------------------------------------------------------------------
module mrta_dp #(
  parameter int unsigned MAX_BLOCKS = mrta_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mrta_pkg::ctrl_cmd_t            cmd_i,
  output mrta_pkg::dp_status_t           status_o,
  // config
  input  logic                           minus_strand_i,
  input  logic [mrta_pkg::CNT_W-1:0]     block_count_i,
  // input word payload
  input  logic [mrta_pkg::IDX_W-1:0]     entry_index_i,
  input  logic [mrta_pkg::POS_W-1:0]     target_start_i,
  input  logic [mrta_pkg::POS_W-1:0]     query_start_i,
  input  logic [mrta_pkg::POS_W-1:0]     block_length_i,
  input  logic [mrta_pkg::POS_W-1:0]     region_first_i,
  input  logic [mrta_pkg::POS_W-1:0]     region_last_i,
  // result
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [mrta_pkg::POS_W-1:0]     mapped_low_o,
  output logic [mrta_pkg::POS_W-1:0]     mapped_high_o,
  output logic                           no_blocks_o
);

  localparam int unsigned AW   = $clog2(MAX_BLOCKS);
  localparam int unsigned CNTW = AW + 1;
  localparam int unsigned PW   = mrta_pkg::POS_W;

  // effective count, saturated at table depth
  logic [CNTW-1:0] cnt_sat;
  logic [CNTW-1:0] cnt_m1;
  assign cnt_sat = (32'(block_count_i) > 32'(MAX_BLOCKS)) ? CNTW'(MAX_BLOCKS)
                                                          : CNTW'(block_count_i);
  assign cnt_m1  = cnt_sat - CNTW'(1);

  // table
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  mrta_pkg::blk_entry_t wentry;
  mrta_pkg::blk_entry_t rentry;

  assign we         = cmd_i.load_wr && (32'(entry_index_i) < 32'(MAX_BLOCKS));
  assign waddr      = AW'(entry_index_i);
  assign wentry.ts  = target_start_i;
  assign wentry.qs  = query_start_i;
  assign wentry.len = block_length_i;

  mrta_ram #(
    .WIDTH (mrta_pkg::ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (rentry)
  );

  // scan state
  logic          issue_q;
  logic          rd_valid_q;
  logic [AW-1:0] scan_addr_q;
  logic [AW-1:0] rd_addr_q;
  logic          end_q;
  logic          empty_q;
  logic [PW-1:0] first_q, last_q;

  logic          restart;
  logic [PW-1:0] pos;
  logic [PW:0]   diff;
  logic          ge;
  logic          hit;

  assign restart = cmd_i.start_map || cmd_i.next_end;
  assign raddr   = scan_addr_q;
  assign pos     = end_q ? last_q : first_q;
  assign diff    = {1'b0, pos} - {1'b0, rentry.ts};
  assign ge      = !diff[PW];
  // first slot from the top at or below pos; slot 0 is the fallback
  assign hit     = rd_valid_q && (ge || (rd_addr_q == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q    <= 1'b0;
      rd_valid_q <= 1'b0;
      end_q      <= 1'b0;
      empty_q    <= 1'b0;
    end else begin
      if (cmd_i.start_map) begin
        end_q   <= 1'b0;
        empty_q <= (cnt_sat == '0);
      end else if (cmd_i.next_end) begin
        end_q <= 1'b1;
      end
      if (restart) begin
        issue_q    <= 1'b1;
        rd_valid_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_valid_q <= issue_q;
        if (issue_q && (scan_addr_q == '0)) begin
          issue_q <= 1'b0;
        end
      end else begin
        rd_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_map) begin
      first_q <= region_first_i;
      last_q  <= region_last_i;
    end
    if (restart) begin
      scan_addr_q <= cnt_m1[AW-1:0];
    end else if (cmd_i.scan && issue_q) begin
      rd_addr_q <= scan_addr_q;
      if (scan_addr_q != '0) begin
        scan_addr_q <= scan_addr_q - AW'(1);
      end
    end
  end

  // offset capture, then clamp and apply
  logic [PW-1:0] off_q, qs_q, len_q;
  logic [PW-1:0] off_c, res;
  logic [PW-1:0] res_a_q, res_b_q;

  assign off_c = (off_q > len_q) ? len_q : off_q;
  assign res   = minus_strand_i ? (qs_q - off_c) : (qs_q + off_c);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && hit) begin
      off_q <= ge ? diff[PW-1:0] : '0;
      qs_q  <= rentry.qs;
      len_q <= rentry.len;
    end
    if (cmd_i.clamp) begin
      if (end_q) begin
        res_b_q <= res;
      end else begin
        res_a_q <= res;
      end
    end
  end

  // output register
  logic          out_valid_q;
  logic [PW-1:0] low_q, high_q;
  logic          nob_q;
  logic          a_le_b;

  assign a_le_b = (res_a_q <= res_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      nob_q <= empty_q;
      if (empty_q) begin
        low_q  <= '0;
        high_q <= '0;
      end else begin
        low_q  <= a_le_b ? res_a_q : res_b_q;
        high_q <= a_le_b ? res_b_q : res_a_q;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign mapped_low_o  = low_q;
  assign mapped_high_o = high_q;
  assign no_blocks_o   = nob_q;

  assign status_o.count_zero = (cnt_sat == '0);
  assign status_o.hit        = hit;
  assign status_o.end_last   = end_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

/* sv/map_region_through_alignment.sv */
// ----------------------------------------------------------------------------
// map_region_through_alignment
// Lifts a target region through a table of alignment blocks onto the query.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+-------------------------------
//  s_axis    | in  | tvalid/tready          | tuser=kind, tdata=load/map word
//  m_axis    | out | tvalid/tready          | tuser=no_blocks, tdata=low/high
//  apb       | in  | psel/penable/pready    | minus_strand @0, block_count @4
//
//  Load word: written straight into the block table.
//  Map word: each end scans the table from slot count-1 downward, one slot a
//  cycle through the table RAM's registered read port, stopping at the first
//  slot whose target start is at or below the position (slot 0 if none).
//  Per end: a scan, then a clamp; the map word's result then moves to the output
//  register. Empty table: no scan or clamp, straight to the output register.
//  Async active-low reset clears control only; the table is not cleared.
//  A held result in the output register holds the next map word at its output step, and no input word is taken then.
//
`include "map_region_through_alignment_macros.svh"

module map_region_through_alignment #(
  parameter int unsigned MAX_BLOCKS = mrta_pkg::MAX_BLOCKS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] kind
  input  logic                              s_axis_tuser,
  // [9:0] entry_index, [41:10] target_start, [73:42] query_start,
  // [105:74] block_length, [137:106] region_first, [169:138] region_last
  input  logic [mrta_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] no_blocks
  output logic                              m_axis_tuser,
  // [31:0] mapped_low, [63:32] mapped_high
  output logic [mrta_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // config port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  localparam int unsigned PW = mrta_pkg::POS_W;

  // register file
  logic                       minus_strand_q;
  logic [mrta_pkg::CNT_W-1:0] block_count_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      minus_strand_q <= 1'b0;
      block_count_q  <= '0;
    end else if (cfg_wr) begin
      case (paddr[2])
        mrta_pkg::REG_MINUS_STRAND: minus_strand_q <= pwdata[0];
        mrta_pkg::REG_BLOCK_COUNT:  block_count_q  <= pwdata[mrta_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      mrta_pkg::REG_MINUS_STRAND: prdata = {31'd0, minus_strand_q};
      mrta_pkg::REG_BLOCK_COUNT:  prdata = 32'(block_count_q);
      default:                    prdata = '0;
    endcase
  end

  // controller / datapath
  mrta_pkg::ctrl_cmd_t  cmd;
  mrta_pkg::dp_status_t status;
  logic [PW-1:0]        mapped_low, mapped_high;

  mrta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mrta_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .minus_strand_i (minus_strand_q),
    .block_count_i  (block_count_q),
    .entry_index_i  (s_axis_tdata[9:0]),
    .target_start_i (s_axis_tdata[41:10]),
    .query_start_i  (s_axis_tdata[73:42]),
    .block_length_i (s_axis_tdata[105:74]),
    .region_first_i (s_axis_tdata[137:106]),
    .region_last_i  (s_axis_tdata[169:138]),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .mapped_low_o   (mapped_low),
    .mapped_high_o  (mapped_high),
    .no_blocks_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {mapped_high, mapped_low};

  // checks; the output flag is cleared asynchronously by reset
  `MRTA_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |=> !m_axis_tvalid, "result word in reset")
  `MRTA_ASSERT(a_ordered,
               m_axis_tvalid |-> (m_axis_tdata[31:0] <= m_axis_tdata[63:32]),
               "low above high")
  `MRTA_ASSERT(a_empty_zero,
               (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0),
               "empty table gave nonzero data")
  `MRTA_ASSERT(a_load_silent,
               (s_axis_tvalid && s_axis_tready && (s_axis_tuser == mrta_pkg::KIND_LOAD)
                && !m_axis_tvalid) |=> !m_axis_tvalid,
               "load word produced a result")

endmodule
